// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL file of the frame deframer.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error(msg);

`endif

// ===== hdl/lpfd_pkg.sv =====
// Constants and widths for the length-prefixed frame deframer.
// Depends on nothing; used by length_prefix_frame_deframer.
package lpfd_pkg;

	localparam int unsigned LEN_W   = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned CFG_IDX_W = 2;

	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [KIND_W-1:0] kind_t;

	localparam len_t  MAX_BODY_RESET     = len_t'(1024 * 1024);
	localparam byte_t HIGHEST_TYPE_RESET = byte_t'(10);

	localparam kind_t KIND_DATA = kind_t'(0);
	localparam kind_t KIND_END  = kind_t'(1);
	localparam kind_t KIND_ERR  = kind_t'(2);

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_TYPE = CFG_IDX_W'(1);

endpackage

// ===== hdl/length_prefix_frame_deframer.sv =====
// Length-prefixed frame deframer: splits a byte stream into typed frames.
// Depends on lpfd_pkg and assert_macros.svh.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    rx_byte
//   out      output     out_valid / out_stall  kind, data_byte, frame_type, frame_last
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// One item is taken every cycle while in_stall is low; its result, if any, passes the input and result registers.
// The input register and the result register form a two-stage pipeline.
// in_stall rises only when both stages are full and the result is stalled.
// Reset restores the register defaults and waits for the first length byte.
`include "assert_macros.svh"

module length_prefix_frame_deframer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [lpfd_pkg::BYTE_W-1:0]      rx_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [lpfd_pkg::KIND_W-1:0]      kind,
	output logic [lpfd_pkg::BYTE_W-1:0]      data_byte,
	output logic [lpfd_pkg::BYTE_W-1:0]      frame_type,
	output logic                             frame_last,
	input  logic                             cfg_we,
	input  logic [lpfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lpfd_pkg::LEN_W-1:0]       cfg_data
);

	typedef enum logic [1:0] {
		PH_LENGTH,
		PH_TYPE,
		PH_PAYLOAD
	} phase_t;

	phase_t              phase_q, phase_d;
	lpfd_pkg::len_t      max_body_q;
	lpfd_pkg::byte_t     highest_type_q;
	lpfd_pkg::len_t      length_shift_q, length_shift_d;
	logic [1:0]          hcount_q, hcount_d;
	lpfd_pkg::len_t      bytes_left_q, bytes_left_d;
	lpfd_pkg::byte_t     cur_type_q, cur_type_d;
	logic                skipping_q, skipping_d;
	logic                halted_q, halted_d;

	logic                valid_s1;
	lpfd_pkg::byte_t     byte_s1;

	logic                out_valid_q;
	lpfd_pkg::kind_t     kind_q;
	lpfd_pkg::byte_t     data_q;
	lpfd_pkg::byte_t     type_q;
	logic                last_q;

	logic                adv;
	logic                in_acc;
	logic                emit;
	lpfd_pkg::kind_t     kind_d;
	lpfd_pkg::byte_t     data_d;
	lpfd_pkg::byte_t     type_d;
	logic                last_d;
	lpfd_pkg::len_t      shifted;
	lpfd_pkg::len_t      dec_left;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign data_byte  = data_q;
	assign frame_type = type_q;
	assign frame_last = last_q;

	always_comb begin
		phase_d        = phase_q;
		length_shift_d = length_shift_q;
		hcount_d       = hcount_q;
		bytes_left_d   = bytes_left_q;
		cur_type_d     = cur_type_q;
		skipping_d     = skipping_q;
		halted_d       = halted_q;
		emit           = 1'b0;
		kind_d         = lpfd_pkg::KIND_DATA;
		data_d         = '0;
		type_d         = '0;
		last_d         = 1'b0;
		shifted        = {length_shift_q[lpfd_pkg::LEN_W-lpfd_pkg::BYTE_W-1:0], byte_s1};
		dec_left       = bytes_left_q - lpfd_pkg::len_t'(1);
		if (!halted_q) begin
			case (phase_q)
				PH_LENGTH: begin
					length_shift_d = shifted;
					if (hcount_q != 2'd3) begin
						hcount_d = hcount_q + 2'd1;
					end else begin
						hcount_d = 2'd0;
						if (shifted == '0 || shifted > max_body_q) begin
							halted_d = 1'b1;
							emit     = 1'b1;
							kind_d   = lpfd_pkg::KIND_ERR;
							last_d   = 1'b1;
						end else begin
							bytes_left_d   = shifted;
							length_shift_d = '0;
							phase_d        = PH_TYPE;
						end
					end
				end
				PH_TYPE: begin
					cur_type_d   = byte_s1;
					skipping_d   = byte_s1 > highest_type_q;
					bytes_left_d = dec_left;
					if (dec_left == '0) begin
						phase_d = PH_LENGTH;
						emit    = !(byte_s1 > highest_type_q);
						kind_d  = lpfd_pkg::KIND_END;
						type_d  = byte_s1;
						last_d  = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
				default: begin
					if (bytes_left_q != '0) begin
						bytes_left_d = dec_left;
					end
					if (bytes_left_d == '0) begin
						phase_d = PH_LENGTH;
					end
					emit   = !skipping_q;
					kind_d = lpfd_pkg::KIND_DATA;
					data_d = byte_s1;
					type_d = cur_type_q;
					last_d = (bytes_left_d == '0);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q     <= lpfd_pkg::MAX_BODY_RESET;
			highest_type_q <= lpfd_pkg::HIGHEST_TYPE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lpfd_pkg::CFG_MAX_BODY:     max_body_q     <= cfg_data;
				lpfd_pkg::CFG_HIGHEST_TYPE: highest_type_q <= cfg_data[lpfd_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_LENGTH;
			length_shift_q <= '0;
			hcount_q       <= 2'd0;
			bytes_left_q   <= '0;
			cur_type_q     <= '0;
			skipping_q     <= 1'b0;
			halted_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && emit;
			if (valid_s1) begin
				phase_q        <= phase_d;
				length_shift_q <= length_shift_d;
				hcount_q       <= hcount_d;
				bytes_left_q   <= bytes_left_d;
				cur_type_q     <= cur_type_d;
				skipping_q     <= skipping_d;
				halted_q       <= halted_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			kind_q <= kind_d;
			data_q <= data_d;
			type_q <= type_d;
			last_q <= last_d;
		end
	end

	// Once an error item has been taken, no further item may follow.
	`ASSERT_CLK(a_err_final, out_valid && !out_stall && kind == lpfd_pkg::KIND_ERR
		|=> !out_valid, "result after length error")
	// Length bytes are only counted while the length is being gathered.
	`ASSERT_CLK(a_hcount_phase, hcount_q != 2'd0 |-> phase_q == PH_LENGTH,
		"header count outside length phase")
	// The payload phase always has at least one byte still to come.
	`ASSERT_NEVER(a_payload_left, phase_q == PH_PAYLOAD && bytes_left_q == '0,
		"payload phase with no bytes left")

endmodule

// ===== tb/length_prefix_frame_deframer_test.sv =====
// Self-checking testbench for length_prefix_frame_deframer: directed and random frames.
// Depends on lpfd_pkg and the deframer RTL; predicts each result with its own frame decoder.
`timescale 1ns / 1ps

module length_prefix_frame_deframer_test;

	typedef logic [lpfd_pkg::CFG_IDX_W-1:0] cfg_idx_t;

	localparam int CYCLE_LIMIT = 250000;
	localparam int RANDOM_ITEMS = 600;
	localparam int MAX_WAIT = 12;
	localparam int SETTLE_CYCLES = 4;
	localparam cfg_idx_t CFG_UNUSED_LO = cfg_idx_t'(2);
	localparam cfg_idx_t CFG_UNUSED_HI = cfg_idx_t'(3);

	typedef enum logic [1:0] {SEEK_LENGTH, SEEK_TYPE, IN_PAYLOAD} deframe_phase_t;

	typedef struct packed {
		lpfd_pkg::kind_t kind;
		lpfd_pkg::byte_t data;
		lpfd_pkg::byte_t ftype;
		logic last;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	lpfd_pkg::byte_t rx_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	lpfd_pkg::kind_t kind;
	lpfd_pkg::byte_t data_byte;
	lpfd_pkg::byte_t frame_type;
	logic frame_last;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = '0;
	lpfd_pkg::len_t cfg_data = '0;

	// Decoder copy of the block state and registers.
	lpfd_pkg::len_t max_body = lpfd_pkg::MAX_BODY_RESET;
	lpfd_pkg::byte_t top_type = lpfd_pkg::HIGHEST_TYPE_RESET;
	deframe_phase_t dec_phase = SEEK_LENGTH;
	lpfd_pkg::len_t len_acc = '0;
	logic [1:0] hdr_cnt = '0;
	lpfd_pkg::len_t body_left = '0;
	lpfd_pkg::byte_t cur_type = '0;
	logic skip_frame = 1'b0;
	logic link_down = 1'b0;

	frame_result_t pending_results[$];
	frame_result_t head_result;

	bit in_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_wait = 0;
	int mismatches = 0;
	int items_sent = 0;
	int frames_sent = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int cycle_count = 0;

	length_prefix_frame_deframer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.data_byte(data_byte),
		.frame_type(frame_type),
		.frame_last(frame_last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: cycle limit reached", $time);
			$display("** length_prefix_frame_deframer: FAILED **");
			$finish;
		end
	end

	function automatic void push_result(input lpfd_pkg::kind_t k, input lpfd_pkg::byte_t d,
		input lpfd_pkg::byte_t t, input logic l);
		frame_result_t r;
		r.kind = k;
		r.data = d;
		r.ftype = t;
		r.last = l;
		pending_results.push_back(r);
	endfunction

	function automatic void decode_byte(input lpfd_pkg::byte_t b);
		if (link_down)
			return;
		case (dec_phase)
			SEEK_LENGTH: begin
				len_acc = {len_acc[23:0], b};
				if (hdr_cnt != 2'd3) begin
					hdr_cnt++;
				end else begin
					hdr_cnt = '0;
					if (len_acc == '0 || len_acc > max_body) begin
						link_down = 1'b1;
						push_result(lpfd_pkg::KIND_ERR, '0, '0, 1'b1);
					end else begin
						body_left = len_acc;
						len_acc = '0;
						dec_phase = SEEK_TYPE;
					end
				end
			end
			SEEK_TYPE: begin
				cur_type = b;
				skip_frame = b > top_type;
				body_left = body_left - 1;
				if (body_left == '0) begin
					dec_phase = SEEK_LENGTH;
					if (!skip_frame)
						push_result(lpfd_pkg::KIND_END, '0, cur_type, 1'b1);
				end else begin
					dec_phase = IN_PAYLOAD;
				end
			end
			default: begin
				if (body_left != '0)
					body_left = body_left - 1;
				if (body_left == '0)
					dec_phase = SEEK_LENGTH;
				if (!skip_frame)
					push_result(lpfd_pkg::KIND_DATA, b, cur_type, body_left == '0);
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, %s %0d %0h %0h %0b",
					$time, "actual kind, data, type, last:",
					kind, data_byte, frame_type, frame_last);
				mismatches++;
			end else begin
				head_result = pending_results.pop_front();
				check_field("kind", 32'(head_result.kind), 32'(kind));
				check_field("data_byte", 32'(head_result.data), 32'(data_byte));
				check_field("frame_type", 32'(head_result.ftype), 32'(frame_type));
				check_field("frame_last", 32'(head_result.last), 32'(frame_last));
			end
			results_checked++;
			rx_wait = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
		end else if (rx_wait > 0) begin
			rx_wait--;
		end
		out_stall <= (rx_wait != 0);
	end

	task automatic send_byte(input lpfd_pkg::byte_t b);
		int gap;
		gap = in_idle ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		decode_byte(b);
		items_sent++;
	endtask

	task automatic send_length(input lpfd_pkg::len_t body_len);
		send_byte(body_len[31:24]);
		send_byte(body_len[23:16]);
		send_byte(body_len[15:8]);
		send_byte(body_len[7:0]);
	endtask

	task automatic send_frame(input lpfd_pkg::len_t body_len, input lpfd_pkg::byte_t ftype);
		int i;
		send_length(body_len);
		send_byte(ftype);
		for (i = 1; i < int'(body_len); i++)
			send_byte(lpfd_pkg::byte_t'($urandom));
		frames_sent++;
	endtask

	// Results for header bytes never come, so the task also lets the pipeline settle after the queue drains.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input lpfd_pkg::len_t value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lpfd_pkg::CFG_MAX_BODY)
			max_body = value;
		else if (idx == lpfd_pkg::CFG_HIGHEST_TYPE)
			top_type = value[7:0];
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic test_directed_frames();
		send_length(lpfd_pkg::len_t'(3));
		send_byte(lpfd_pkg::HIGHEST_TYPE_RESET);
		send_byte(8'h00);
		send_byte(8'hFF);
		frames_sent++;
		send_frame(lpfd_pkg::len_t'(1), lpfd_pkg::HIGHEST_TYPE_RESET + 8'd1);
		wait_idle();
		write_register(lpfd_pkg::CFG_HIGHEST_TYPE, lpfd_pkg::len_t'(0));
		write_register(lpfd_pkg::CFG_MAX_BODY, lpfd_pkg::len_t'(1));
		send_frame(lpfd_pkg::len_t'(1), 8'h00);
		wait_idle();
		write_register(lpfd_pkg::CFG_HIGHEST_TYPE,
			{24'($urandom_range(0, 24'hFFFFFF)), 8'hFF});
		write_register(lpfd_pkg::CFG_MAX_BODY, 32'hFFFF_FFFF);
		write_register(CFG_UNUSED_LO, lpfd_pkg::len_t'(0));
		write_register(CFG_UNUSED_HI, lpfd_pkg::len_t'($urandom));
		send_frame(lpfd_pkg::len_t'(2), 8'hFF);
		wait_idle();
	endtask

	task automatic test_mid_frame_config();
		send_length(lpfd_pkg::len_t'(3));
		wait_idle();
		write_register(lpfd_pkg::CFG_HIGHEST_TYPE, lpfd_pkg::len_t'(6));
		send_byte(8'h07);
		send_byte(lpfd_pkg::byte_t'($urandom));
		send_byte(lpfd_pkg::byte_t'($urandom));
		frames_sent++;
		wait_idle();
	endtask

	task automatic reconfigure();
		int pick;
		wait_idle();
		pick = $urandom_range(0, 4);
		case (pick)
			0: write_register(lpfd_pkg::CFG_MAX_BODY, lpfd_pkg::len_t'(1));
			1: write_register(lpfd_pkg::CFG_MAX_BODY, lpfd_pkg::len_t'($urandom_range(1, 40)));
			2: write_register(lpfd_pkg::CFG_MAX_BODY, lpfd_pkg::MAX_BODY_RESET);
			3: write_register(lpfd_pkg::CFG_MAX_BODY, 32'hFFFF_FFFF);
			default: write_register(lpfd_pkg::CFG_MAX_BODY,
				lpfd_pkg::len_t'($urandom) | lpfd_pkg::len_t'(1));
		endcase
		pick = $urandom_range(0, 2);
		case (pick)
			0: write_register(lpfd_pkg::CFG_HIGHEST_TYPE, lpfd_pkg::len_t'(0));
			1: write_register(lpfd_pkg::CFG_HIGHEST_TYPE, lpfd_pkg::len_t'(255));
			default: write_register(lpfd_pkg::CFG_HIGHEST_TYPE, lpfd_pkg::len_t'($urandom));
		endcase
		if ($urandom_range(0, 3) == 0)
			write_register($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
				lpfd_pkg::len_t'($urandom));
		in_idle = $urandom_range(0, 3) != 0;
		rx_idle = $urandom_range(0, 3) != 0;
	endtask

	task automatic test_random_frames();
		int stop_at;
		int until_reconfig;
		int cap;
		int frame_no;
		lpfd_pkg::len_t body_len;
		lpfd_pkg::byte_t ftype;
		stop_at = items_sent + RANDOM_ITEMS;
		until_reconfig = 0;
		frame_no = 0;
		while (items_sent < stop_at) begin
			if (until_reconfig == 0) begin
				reconfigure();
				until_reconfig = $urandom_range(6, 14);
			end
			until_reconfig--;
			if (frame_no == 20)
				wait_idle();
			cap = (max_body < 40) ? int'(max_body) : 40;
			if ($urandom_range(0, 9) < 8)
				body_len = lpfd_pkg::len_t'($urandom_range(1, (cap < 8) ? cap : 8));
			else
				body_len = lpfd_pkg::len_t'($urandom_range(1, cap));
			if ($urandom_range(0, 9) < 7)
				ftype = lpfd_pkg::byte_t'($urandom_range(0, top_type));
			else
				ftype = lpfd_pkg::byte_t'($urandom_range(0, 255));
			send_frame(body_len, ftype);
			frame_no++;
		end
		wait_idle();
	endtask

	// The link stays dropped until reset, so this case closes the run.
	task automatic test_bad_length();
		int i;
		write_register(lpfd_pkg::CFG_MAX_BODY, lpfd_pkg::len_t'($urandom_range(1, 1000)));
		if ($urandom_range(0, 1))
			send_length(lpfd_pkg::len_t'(0));
		else
			send_length(max_body + lpfd_pkg::len_t'($urandom_range(1, 1 << 20)));
		for (i = 0; i < 16; i++)
			send_byte(lpfd_pkg::byte_t'($urandom));
		wait_idle();
		write_register(lpfd_pkg::CFG_HIGHEST_TYPE, lpfd_pkg::len_t'(255));
		send_frame(lpfd_pkg::len_t'(2), 8'h00);
		wait_idle();
	endtask

	initial begin
		int n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_mid_frame_config();
		test_random_frames();
		test_bad_length();
		for (n = 0; n < 2000 && pending_results.size() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t ns: %0d expected results never arrived", $time, pending_results.size());
			mismatches += pending_results.size();
		end
		$display("Sent %0d bytes in %0d frames with %0d register writes; checked %0d results.",
			items_sent, frames_sent, reg_writes, results_checked);
		$display("Covered empty and skipped frames, mid-frame changes and the dropped link.");
		if (mismatches == 0)
			$display("** length_prefix_frame_deframer: PASSED **");
		else
			$display("** length_prefix_frame_deframer: FAILED **");
		$finish;
	end

endmodule
